// File: hdl/pdc_pkg.sv
// Shared widths, register indexes and stage types of the PID drive controller.
`timescale 1ns / 1ps

package pdc_pkg;

    // Fixed-point format and output limit
    localparam int FRAC_BITS   = 8;
    localparam int DRIVE_LIMIT = 127;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int ISUM_W   = 32;
    localparam int DRIVE_W  = 8;

    // Product and mix widths
    localparam int PROD_P_W = ERR_W + GAIN_W;
    localparam int PROD_I_W = ISUM_W + GAIN_W;
    localparam int PROD_D_W = DERIV_W + GAIN_W;
    localparam int MIX_W    = PROD_I_W + 2;
    localparam int WHOLE_W  = MIX_W - FRAC_BITS;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RUN_ENABLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D     = 3'd4;

    // Products of one beat on their way to the mix stage
    typedef struct packed {
        logic                       en;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } t_mix_in;

endpackage

// File: hdl/pid_drive_controller_core.sv
// Top level of the PID drive controller: config registers, loop state and pipeline.
//
//  Channel   Dir  Handshake                         Payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata[15:0] = sensor_value
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata[7:0]  = drive
//  cfg       in   i_cfg_we                           i_cfg_addr, i_cfg_wdata[15:0]
//
// One beat in and one beat out per clock while the output is not stalled; a beat
// passes the error/integral register, product register and output register in turn.
// The integral and prior error update in the first stage, so beats may follow
// back to back. Each stage holds while the one after it is full and stalled.
// i_rst_n low clears config, loop state, held drive and all valid bits.
`timescale 1ns / 1ps

module pid_drive_controller_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // stream in: sensor_value[15:0]
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [pdc_pkg::SAMPLE_W-1:0]       i_s_axis_tdata,
    // stream out: drive[7:0]
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [pdc_pkg::DRIVE_W-1:0]        o_m_axis_tdata,
    // register writes
    input  logic                               i_cfg_we,
    input  logic [pdc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pdc_pkg::GAIN_W-1:0]         i_cfg_wdata
);

    // Configuration
    logic                                 r_run_enable;
    logic signed [pdc_pkg::SAMPLE_W-1:0]  r_target;
    logic signed [pdc_pkg::GAIN_W-1:0]    r_gain_p;
    logic signed [pdc_pkg::GAIN_W-1:0]    r_gain_i;
    logic signed [pdc_pkg::GAIN_W-1:0]    r_gain_d;

    // Loop state
    logic signed [pdc_pkg::ISUM_W-1:0]    r_error_sum;
    logic signed [pdc_pkg::ERR_W-1:0]     r_prior_error;
    logic signed [pdc_pkg::DRIVE_W-1:0]   r_held_drive;

    // Stage valids
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic s_accept;

    // Stage 1 payload
    logic                                 r_en1;
    logic signed [pdc_pkg::ERR_W-1:0]     r_err1;
    logic signed [pdc_pkg::ISUM_W-1:0]    r_isum1;
    logic signed [pdc_pkg::DERIV_W-1:0]   r_deriv1;

    // Stage 2 payload and output register
    pdc_pkg::t_mix_in                     r_mix2;
    logic signed [pdc_pkg::DRIVE_W-1:0]   r_drive3;

    // First-stage arithmetic
    logic signed [pdc_pkg::SAMPLE_W-1:0]  sample;
    logic signed [pdc_pkg::ERR_W-1:0]     n_err;
    logic signed [pdc_pkg::ISUM_W:0]      acc;
    logic signed [pdc_pkg::ISUM_W-1:0]    n_error_sum;
    logic signed [pdc_pkg::DERIV_W-1:0]   n_deriv;

    logic signed [pdc_pkg::DRIVE_W-1:0]   mix_drive;

    // Handshake: a stage takes a beat when empty or when it is passing one on
    assign rdy3            = ~r_v3 | i_m_axis_tready;
    assign rdy2            = ~r_v2 | rdy3;
    assign rdy1            = ~r_v1 | rdy2;
    assign o_s_axis_tready = rdy1;
    assign s_accept        = i_s_axis_tvalid & rdy1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable <= 1'b0;
            r_target     <= '0;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pdc_pkg::CFG_RUN_ENABLE: r_run_enable <= i_cfg_wdata[0];
                pdc_pkg::CFG_TARGET:     r_target     <= i_cfg_wdata;
                pdc_pkg::CFG_GAIN_P:     r_gain_p     <= i_cfg_wdata;
                pdc_pkg::CFG_GAIN_I:     r_gain_i     <= i_cfg_wdata;
                pdc_pkg::CFG_GAIN_D:     r_gain_d     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Error, saturated integral and derivative of the incoming sample
    assign sample  = i_s_axis_tdata;
    assign n_err   = pdc_pkg::ERR_W'(r_target) - pdc_pkg::ERR_W'(sample);
    assign acc     = (pdc_pkg::ISUM_W + 1)'(r_error_sum) + (pdc_pkg::ISUM_W + 1)'(n_err);
    assign n_deriv = pdc_pkg::DERIV_W'(r_prior_error) - pdc_pkg::DERIV_W'(n_err);

    always_comb begin
        if (acc[pdc_pkg::ISUM_W] != acc[pdc_pkg::ISUM_W-1]) begin
            // Overflow: pin to the extreme of the sign
            n_error_sum = {acc[pdc_pkg::ISUM_W], {(pdc_pkg::ISUM_W-1){~acc[pdc_pkg::ISUM_W]}}};
        end else begin
            n_error_sum = acc[pdc_pkg::ISUM_W-1:0];
        end
    end

    // Advance loop state on each enabled beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum   <= '0;
            r_prior_error <= '0;
        end else if (s_accept && r_run_enable) begin
            r_error_sum   <= n_error_sum;
            r_prior_error <= n_err;
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Stage 1: capture error terms
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_en1    <= r_run_enable;
            r_err1   <= n_err;
            r_isum1  <= n_error_sum;
            r_deriv1 <= n_deriv;
        end
    end

    // Stage 2: multiply by the gains
    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_mix2.en     <= r_en1;
            r_mix2.prod_p <= r_err1 * r_gain_p;
            r_mix2.prod_i <= r_isum1 * r_gain_i;
            r_mix2.prod_d <= r_deriv1 * r_gain_d;
        end
    end

    pdc_mix u_mix (
        .i_mix        (r_mix2),
        .i_held_drive (r_held_drive),
        .o_drive      (mix_drive)
    );

    // Stage 3: output register and held drive
    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_drive3 <= mix_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_drive <= '0;
        end else if (rdy3 && r_v2 && r_mix2.en) begin
            r_held_drive <= mix_drive;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = r_drive3;

endmodule

// File: hdl/pdc_mix.sv
// Sum of the three PID terms, truncation toward zero and output clamp.
`timescale 1ns / 1ps

module pdc_mix (
    input  pdc_pkg::t_mix_in                       i_mix,
    input  logic signed [pdc_pkg::DRIVE_W-1:0]     i_held_drive,
    output logic signed [pdc_pkg::DRIVE_W-1:0]     o_drive
);

    localparam logic signed [pdc_pkg::WHOLE_W-1:0] LIM_HI =
        pdc_pkg::WHOLE_W'(pdc_pkg::DRIVE_LIMIT);
    localparam logic signed [pdc_pkg::WHOLE_W-1:0] LIM_LO =
        -pdc_pkg::WHOLE_W'(pdc_pkg::DRIVE_LIMIT);

    logic signed [pdc_pkg::MIX_W-1:0]   mix_sum;
    logic signed [pdc_pkg::WHOLE_W-1:0] whole_floor;
    logic signed [pdc_pkg::WHOLE_W-1:0] whole;
    logic                               round_up;
    logic signed [pdc_pkg::WHOLE_W-1:0] clamped;

    // Add the weighted terms
    assign mix_sum = pdc_pkg::MIX_W'(i_mix.prod_p)
                   + pdc_pkg::MIX_W'(i_mix.prod_i)
                   + pdc_pkg::MIX_W'(i_mix.prod_d);

    // Drop the fraction, rounding negative values toward zero
    assign whole_floor = pdc_pkg::WHOLE_W'(mix_sum >>> pdc_pkg::FRAC_BITS);
    assign round_up    = mix_sum[pdc_pkg::MIX_W-1] & (|mix_sum[pdc_pkg::FRAC_BITS-1:0]);
    assign whole       = whole_floor + pdc_pkg::WHOLE_W'(round_up);

    // Clamp to the drive limit
    always_comb begin
        if (whole > LIM_HI) begin
            clamped = LIM_HI;
        end else if (whole < LIM_LO) begin
            clamped = LIM_LO;
        end else begin
            clamped = whole;
        end
    end

    // Repeat the held drive while the loop is frozen
    assign o_drive = i_mix.en ? clamped[pdc_pkg::DRIVE_W-1:0] : i_held_drive;

endmodule
